@@ src/rtc_pkg.sv @@
// rtc_pkg: shared types, codes and constants of the real-time clock calendar
// holds the calendar and configuration structs and the month length table
// no dependencies
`default_nettype none

package rtc_pkg;

   // request kinds carried in req_tuser
   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_UP   = 2'd1;
   localparam logic [1:0] MODE_DOWN = 2'd2;

   // field selectors for manual steps
   localparam logic [2:0] FIELD_MINUTE = 3'd0;
   localparam logic [2:0] FIELD_HOUR   = 3'd1;
   localparam logic [2:0] FIELD_DAY    = 3'd2;
   localparam logic [2:0] FIELD_MONTH  = 3'd3;
   localparam logic [2:0] FIELD_YEAR   = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_TICKS_PER_MINUTE = 2'd0;
   localparam logic [1:0] CSR_ALARM_ENABLE     = 2'd1;
   localparam logic [1:0] CSR_ALARM_HOUR       = 2'd2;
   localparam logic [1:0] CSR_ALARM_MINUTE     = 2'd3;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;

   // reset values
   localparam logic [7:0] TICKS_PER_MINUTE_RST = 8'd114;
   localparam logic [5:0] MINUTE_RST = 6'd59;
   localparam logic [4:0] HOUR_RST   = 5'd5;
   localparam logic [4:0] DAY_RST    = 5'd1;
   localparam logic [3:0] MONTH_RST  = 4'd2;
   localparam logic [6:0] YEAR_RST   = 7'd23;

   // field limits
   localparam logic [5:0] MINUTE_MAX = 6'd59;
   localparam logic [4:0] HOUR_MAX   = 5'd23;
   localparam logic [3:0] MONTH_MAX  = 4'd12;
   localparam logic [6:0] YEAR_MAX   = 7'd99;

   typedef struct packed {
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] day;
      logic [3:0] month;
      logic [6:0] year;
   } cal_type;

   typedef struct packed {
      logic [7:0] ticks_per_minute;
      logic       alarm_enable;
      logic [4:0] alarm_hour;
      logic [5:0] alarm_minute;
   } cfg_type;

   // days in a month, no leap years
   function automatic logic [4:0] month_length(input logic [3:0] m);
      logic [4:0] len;
      case (m)
         4'd2:                      len = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

@@ src/rtc_calendar_alarm.sv @@
// rtc_calendar_alarm: real-time clock calendar with minute alarm
// the result of an accepted request is registered and shows on rsp_* in the next cycle
// throughput: one request per cycle while no result is held or it is being taken
// reset (synchronous, active high): 05:59 on day 1 of month 2, year 23,
// prescale count 0, ticks_per_minute 114, alarm off at 00:00, no result held
// depends on rtc_pkg, rtc_csr, rtc_next
`default_nettype none

module rtc_calendar_alarm (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [7:0]                     req_tdata,  // [2:0] field_select
   input  wire logic [1:0]                     req_tuser,  // [1:0] mode
   // result channel
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [5:0] minute_now, [10:6] hour_now, [15:11] day_now, [19:16] month_now,
   // [26:20] year_now
   output logic [31:0]                         rsp_tdata,
   output logic [1:0]                          rsp_tuser,  // [0] minute_rolled, [1] alarm_hit
   // configuration port
   input  wire logic                           csr_we,
   input  wire logic [rtc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [rtc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rtc_pkg::*;

   cfg_type    cfg;
   cal_type    cal_ff, cal_in;
   logic [7:0] tick_ff, tick_in;
   logic       rsp_valid_ff;
   cal_type    out_cal_ff;
   logic       rolled_ff, hit_ff;
   logic       rolled_in, hit_in;
   logic       req_accept;

   rtc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rtc_next u_next (
      .cal          (cal_ff),
      .tick_count   (tick_ff),
      .cfg          (cfg),
      .mode         (req_tuser),
      .field_select (req_tdata[2:0]),
      .cal_next     (cal_in),
      .tick_next    (tick_in),
      .rolled       (rolled_in),
      .hit          (hit_in)
   );

   // accept while the result register is empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // calendar and prescale state
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff.minute <= MINUTE_RST;
         cal_ff.hour   <= HOUR_RST;
         cal_ff.day    <= DAY_RST;
         cal_ff.month  <= MONTH_RST;
         cal_ff.year   <= YEAR_RST;
         tick_ff       <= 8'd0;
      end else if (req_accept) begin
         cal_ff  <= cal_in;
         tick_ff <= tick_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (req_accept)
         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_valid_ff <= 1'b0;
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         out_cal_ff <= cal_in;
         rolled_ff  <= rolled_in;
         hit_ff     <= hit_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, out_cal_ff.year, out_cal_ff.month, out_cal_ff.day,
                        out_cal_ff.hour, out_cal_ff.minute};
   assign rsp_tuser  = {hit_ff, rolled_ff};

   // an alarm hit only comes with a minute roll
   a_hit_needs_roll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!hit_ff || rolled_ff))
      else $error("alarm hit without minute roll");

   // manual steps and unused kinds never roll a minute
   a_step_no_roll: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser != MODE_TICK) |=> !rolled_ff)
      else $error("minute roll on a non-tick request");

   // manual steps leave the prescale count alone
   a_step_keeps_tick: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser != MODE_TICK) |=> $stable(tick_ff))
      else $error("prescale count changed by a step");

   // time of day stays in range
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      (cal_ff.minute <= MINUTE_MAX) && (cal_ff.hour <= HOUR_MAX))
      else $error("time of day out of range");

   // result register reflects the live calendar after an accepted request
   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (out_cal_ff == cal_ff))
      else $error("result differs from calendar state");

endmodule

`default_nettype wire

@@ src/rtc_csr.sv @@
// rtc_csr: configuration registers of the real-time clock calendar
// plain write port, no read-back; depends on rtc_pkg
`default_nettype none

module rtc_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [rtc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [rtc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output rtc_pkg::cfg_type                    cfg
);
   import rtc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_TICKS_PER_MINUTE: cfg_in.ticks_per_minute = csr_wdata;
            CSR_ALARM_ENABLE:     cfg_in.alarm_enable     = csr_wdata[0];
            CSR_ALARM_HOUR:       cfg_in.alarm_hour       = csr_wdata[4:0];
            CSR_ALARM_MINUTE:     cfg_in.alarm_minute     = csr_wdata[5:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_minute <= TICKS_PER_MINUTE_RST;
         cfg_ff.alarm_enable     <= 1'b0;
         cfg_ff.alarm_hour       <= 5'd0;
         cfg_ff.alarm_minute     <= 6'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ src/rtc_next.sv @@
// rtc_next: next calendar and prescale value for one request
// pure combinational carry and step logic; depends on rtc_pkg
`default_nettype none

module rtc_next (
   input  wire rtc_pkg::cal_type cal,
   input  wire logic [7:0]       tick_count,
   input  wire rtc_pkg::cfg_type cfg,
   input  wire logic [1:0]       mode,
   input  wire logic [2:0]       field_select,
   output rtc_pkg::cal_type      cal_next,
   output logic [7:0]            tick_next,
   output logic                  rolled,
   output logic                  hit
);
   import rtc_pkg::*;

   logic [8:0] tick_sum;
   logic       tick_roll;
   logic [4:0] len;
   logic       min_carry, hour_carry, day_carry, month_carry;
   cal_type    cal_roll;
   cal_type    cal_step;
   logic       step_up;

   assign len = month_length(cal.month);

   // prescale counter, roll when the incremented count reaches or passes the limit
   assign tick_sum  = {1'b0, tick_count} + 9'd1;
   assign tick_roll = (tick_sum >= {1'b0, cfg.ticks_per_minute});

   // minute roll with carry through the calendar
   assign min_carry   = (cal.minute >= MINUTE_MAX);
   assign hour_carry  = min_carry && (cal.hour >= HOUR_MAX);
   assign day_carry   = hour_carry && (cal.day >= len);
   assign month_carry = day_carry && (cal.month >= MONTH_MAX);

   always_comb begin
      cal_roll = cal;
      cal_roll.minute = min_carry ? 6'd0 : cal.minute + 6'd1;
      if (min_carry)
         cal_roll.hour = (cal.hour >= HOUR_MAX) ? 5'd0 : cal.hour + 5'd1;
      if (hour_carry)
         cal_roll.day = (cal.day >= len) ? 5'd1 : cal.day + 5'd1;
      if (day_carry)
         cal_roll.month = (cal.month >= MONTH_MAX) ? 4'd1 : cal.month + 4'd1;
      if (month_carry)
         cal_roll.year = (cal.year >= YEAR_MAX) ? 7'd0 : cal.year + 7'd1;
   end

   // manual single-field step, no carry
   assign step_up = (mode == MODE_UP);

   always_comb begin
      cal_step = cal;
      unique case (field_select)
         FIELD_MINUTE: begin
            if (step_up)
               cal_step.minute = (cal.minute >= MINUTE_MAX) ? 6'd0 : cal.minute + 6'd1;
            else
               cal_step.minute = (cal.minute == 6'd0) ? MINUTE_MAX : cal.minute - 6'd1;
         end
         FIELD_HOUR: begin
            if (step_up)
               cal_step.hour = (cal.hour >= HOUR_MAX) ? 5'd0 : cal.hour + 5'd1;
            else
               cal_step.hour = (cal.hour == 5'd0) ? HOUR_MAX : cal.hour - 5'd1;
         end
         FIELD_DAY: begin
            if (step_up)
               cal_step.day = (cal.day >= len) ? 5'd1 : cal.day + 5'd1;
            else
               cal_step.day = (cal.day <= 5'd1) ? len : cal.day - 5'd1;
         end
         FIELD_MONTH: begin
            if (step_up)
               cal_step.month = (cal.month >= MONTH_MAX) ? 4'd1 : cal.month + 4'd1;
            else
               cal_step.month = (cal.month <= 4'd1) ? MONTH_MAX : cal.month - 4'd1;
         end
         FIELD_YEAR: begin
            if (step_up)
               cal_step.year = (cal.year >= YEAR_MAX) ? 7'd0 : cal.year + 7'd1;
            else
               cal_step.year = (cal.year == 7'd0) ? 7'd0 : cal.year - 7'd1;
         end
         default: cal_step = cal;
      endcase
   end

   // select by request kind
   always_comb begin
      cal_next  = cal;
      tick_next = tick_count;
      rolled    = 1'b0;
      hit       = 1'b0;
      unique case (mode)
         MODE_TICK: begin
            if (tick_roll) begin
               cal_next  = cal_roll;
               tick_next = 8'd0;
               rolled    = 1'b1;
               hit       = cfg.alarm_enable && (cal_roll.hour == cfg.alarm_hour)
                           && (cal_roll.minute == cfg.alarm_minute);
            end else begin
               tick_next = tick_sum[7:0];
            end
         end
         MODE_UP, MODE_DOWN: cal_next = cal_step;
         default: cal_next = cal;
      endcase
   end

endmodule

`default_nettype wire

@@ tb/tb_rtc_calendar_alarm.sv @@
// tb_rtc_calendar_alarm: self-checking testbench for the real-time clock calendar
// predicts every response from its own calendar copy and compares field by field
// depends on rtc_pkg and rtc_calendar_alarm
`timescale 1ns / 1ps

module tb_rtc_calendar_alarm;

   import rtc_pkg::*;

   localparam int TOTAL_REQUESTS = 1275;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      cal_type cal;
      logic    rolled;
      logic    hit;
   } reading_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // predicted calendar, prescale count and settings
   cal_type     model_cal   = '{minute: MINUTE_RST, hour: HOUR_RST, day: DAY_RST,
                                month: MONTH_RST, year: YEAR_RST};
   logic [8:0]  model_ticks = '0;
   cfg_type     model_cfg   = '{ticks_per_minute: TICKS_PER_MINUTE_RST,
                                alarm_enable: 1'b0, alarm_hour: '0, alarm_minute: '0};
   reading_type expected_readings[$];

   int   mismatches    = 0;
   int   requests_sent = 0;
   int   idle_cycles   = 0;
   int   stall_left    = 0;
   logic gaps_on       = 1'b1;
   logic stalls_on     = 1'b1;

   rtc_calendar_alarm u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // calendar predictor
   // ------------------------------------------------------------------

   // days in a month, no leap years
   function automatic logic [4:0] days_in_month(input logic [3:0] m);
      case (m)
         4'd2:                    return 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
         default:                 return 5'd31;
      endcase
   endfunction

   // one minute with carry through hour, day, month and year
   function automatic void add_minute();
      if (model_cal.minute < MINUTE_MAX) begin
         model_cal.minute = model_cal.minute + 6'd1;
      end else begin
         model_cal.minute = '0;
         if (model_cal.hour < HOUR_MAX) begin
            model_cal.hour = model_cal.hour + 5'd1;
         end else begin
            model_cal.hour = '0;
            // a day at or past the month length carries
            if (model_cal.day < days_in_month(model_cal.month)) begin
               model_cal.day = model_cal.day + 5'd1;
            end else begin
               model_cal.day = 5'd1;
               if (model_cal.month < MONTH_MAX) begin
                  model_cal.month = model_cal.month + 4'd1;
               end else begin
                  model_cal.month = 4'd1;
                  model_cal.year  = (model_cal.year >= YEAR_MAX) ? 7'd0
                                                                 : model_cal.year + 7'd1;
               end
            end
         end
      end
   endfunction

   // manual step of one field without carry, wrapping except for year down
   function automatic void step_field(input logic [2:0] field, input logic up);
      logic [4:0] len;
      len = days_in_month(model_cal.month);
      case (field)
         FIELD_MINUTE:
            model_cal.minute = up ? ((model_cal.minute >= MINUTE_MAX) ? 6'd0
                                                                      : model_cal.minute + 6'd1)
                                  : ((model_cal.minute == 6'd0) ? MINUTE_MAX
                                                                : model_cal.minute - 6'd1);
         FIELD_HOUR:
            model_cal.hour = up ? ((model_cal.hour >= HOUR_MAX) ? 5'd0 : model_cal.hour + 5'd1)
                                : ((model_cal.hour == 5'd0) ? HOUR_MAX : model_cal.hour - 5'd1);
         FIELD_DAY:
            model_cal.day = up ? ((model_cal.day >= len) ? 5'd1 : model_cal.day + 5'd1)
                               : ((model_cal.day <= 5'd1) ? len : model_cal.day - 5'd1);
         FIELD_MONTH:
            model_cal.month = up ? ((model_cal.month >= MONTH_MAX) ? 4'd1
                                                                   : model_cal.month + 4'd1)
                                 : ((model_cal.month <= 4'd1) ? MONTH_MAX
                                                              : model_cal.month - 4'd1);
         FIELD_YEAR:
            // year down saturates at zero
            model_cal.year = up ? ((model_cal.year >= YEAR_MAX) ? 7'd0 : model_cal.year + 7'd1)
                                : ((model_cal.year == 7'd0) ? 7'd0 : model_cal.year - 7'd1);
         default: ;
      endcase
   endfunction

   // apply one accepted request and queue the expected response
   function automatic void predict_request(input logic [1:0] mode, input logic [2:0] field);
      reading_type r;
      r.rolled = 1'b0;
      r.hit    = 1'b0;
      case (mode)
         MODE_TICK: begin
            model_ticks = model_ticks + 9'd1;
            if (model_ticks >= {1'b0, model_cfg.ticks_per_minute}) begin
               model_ticks = '0;
               add_minute();
               r.rolled = 1'b1;
               // compare uses the time after the minute was added
               r.hit = model_cfg.alarm_enable && model_cal.hour == model_cfg.alarm_hour &&
                       model_cal.minute == model_cfg.alarm_minute;
            end
         end
         MODE_UP:   step_field(field, 1'b1);
         MODE_DOWN: step_field(field, 1'b0);
         default: ;
      endcase
      r.cal = model_cal;
      expected_readings.push_back(r);
   endfunction

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      return ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2) : $urandom_range(3, 24);
   endfunction

   // send one request, then an optional idle gap
   task automatic send_request(input logic [1:0] mode, input logic [2:0] field);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {5'b0, field};
      do @(posedge clock); while (!req_tready);
      predict_request(mode, field);
      requests_sent++;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop requesting and let every outstanding response arrive
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // write all four registers back to back while the block is idle
   task automatic write_settings(input logic [7:0] tpm, input logic en,
                                 input logic [4:0] ah, input logic [5:0] am);
      wait_for_results();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_TICKS_PER_MINUTE;
      csr_wdata <= tpm;
      @(posedge clock);
      csr_addr  <= CSR_ALARM_ENABLE;
      csr_wdata <= {7'b0, en};
      @(posedge clock);
      csr_addr  <= CSR_ALARM_HOUR;
      csr_wdata <= {3'b0, ah};
      @(posedge clock);
      csr_addr  <= CSR_ALARM_MINUTE;
      csr_wdata <= {2'b0, am};
      @(posedge clock);
      csr_we    <= 1'b0;
      model_cfg = '{ticks_per_minute: tpm, alarm_enable: en, alarm_hour: ah,
                    alarm_minute: am};
   endtask

   // response side back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
         stall_left <= pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // response checking
   // ------------------------------------------------------------------

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         if (mismatches < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_responses
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("%0t: response with no request outstanding, data %h user %b",
                        $realtime, rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            want = expected_readings.pop_front();
            check_field("minute_now",    int'(want.cal.minute), int'(rsp_tdata[5:0]));
            check_field("hour_now",      int'(want.cal.hour),   int'(rsp_tdata[10:6]));
            check_field("day_now",       int'(want.cal.day),    int'(rsp_tdata[15:11]));
            check_field("month_now",     int'(want.cal.month),  int'(rsp_tdata[19:16]));
            check_field("year_now",      int'(want.cal.year),   int'(rsp_tdata[26:20]));
            check_field("minute_rolled", int'(want.rolled),     int'(rsp_tuser[0]));
            check_field("alarm_hit",     int'(want.hit),        int'(rsp_tuser[1]));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_rtc_calendar_alarm NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // unused mode and field codes leave the calendar alone
   task automatic test_unused_codes();
      send_request(2'd3, FIELD_MINUTE);
      send_request(MODE_UP, 3'd5);
      send_request(MODE_DOWN, 3'd7);
      send_request(2'd3, 3'd7);
   endtask

   // minute wraps in both directions, hour steps up and down
   task automatic test_minute_hour_steps();
      send_request(MODE_UP, FIELD_MINUTE);
      send_request(MODE_DOWN, FIELD_MINUTE);
      send_request(MODE_UP, FIELD_HOUR);
      send_request(MODE_DOWN, FIELD_HOUR);
   endtask

   // day wrap by month length, month wrap, day left beyond the month
   task automatic test_day_month_steps();
      send_request(MODE_DOWN, FIELD_DAY);
      send_request(MODE_UP, FIELD_DAY);
      send_request(MODE_DOWN, FIELD_MONTH);
      send_request(MODE_DOWN, FIELD_MONTH);
      send_request(MODE_UP, FIELD_MONTH);
      send_request(MODE_DOWN, FIELD_DAY);
      send_request(MODE_UP, FIELD_MONTH);
      send_request(MODE_UP, FIELD_DAY);
   endtask

   task automatic test_year_steps();
      send_request(MODE_UP, FIELD_YEAR);
      send_request(MODE_DOWN, FIELD_YEAR);
   endtask

   // zero prescale rolls on every tick, alarm fires on the new time
   task automatic test_tick_carry();
      write_settings(8'd0, 1'b1, 5'd6, 6'd0);
      send_request(MODE_TICK, FIELD_MINUTE);
      send_request(MODE_TICK, 3'd7);
   endtask

   // prescale lowered below the running count, then register extremes
   task automatic test_prescale();
      write_settings(8'd3, 1'b0, 5'd0, 6'd0);
      send_request(MODE_TICK, FIELD_MINUTE);
      send_request(MODE_TICK, FIELD_MINUTE);
      write_settings(8'd1, 1'b1, HOUR_RST, 6'd0);
      send_request(MODE_TICK, FIELD_MINUTE);
      write_settings(8'd255, 1'b1, 5'd31, 6'd63);
      send_request(MODE_TICK, FIELD_MINUTE);
   endtask

   // new settings, alarm often placed just ahead of the clock
   task automatic random_settings();
      int         pick;
      logic [7:0] tpm;
      logic       en;
      logic [4:0] ah;
      logic [5:0] am;
      pick = $urandom_range(0, 99);
      if (pick < 40)      tpm = 8'($urandom_range(0, 3));
      else if (pick < 70) tpm = 8'($urandom_range(4, 20));
      else if (pick < 85) tpm = 8'($urandom_range(254, 255));
      else                tpm = 8'($urandom_range(0, 255));
      en = ($urandom_range(0, 9) < 7);
      if ($urandom_range(0, 1)) begin
         ah = model_cal.hour;
         am = 6'((model_cal.minute + $urandom_range(1, 3)) % 60);
      end else begin
         ah = 5'($urandom_range(0, 31));
         am = 6'($urandom_range(0, 63));
      end
      write_settings(tpm, en, ah, am);
   endtask

   function automatic int field_now(input logic [2:0] field);
      case (field)
         FIELD_MINUTE: return int'(model_cal.minute);
         FIELD_HOUR:   return int'(model_cal.hour);
         FIELD_DAY:    return int'(model_cal.day);
         FIELD_MONTH:  return int'(model_cal.month);
         default:      return int'(model_cal.year);
      endcase
   endfunction

   function automatic int field_span(input logic [2:0] field);
      case (field)
         FIELD_MINUTE: return 60;
         FIELD_HOUR:   return 24;
         FIELD_DAY:    return int'(days_in_month(model_cal.month));
         FIELD_MONTH:  return 12;
         default:      return 100;
      endcase
   endfunction

   // step one field to a target by the shorter way round
   task automatic walk_field(input logic [2:0] field, input int target);
      int cur, span, up_dist, down_dist;
      cur = field_now(field);
      while (cur != target) begin
         span      = field_span(field);
         up_dist   = (target - cur + span) % span;
         down_dist = (cur - target + span) % span;
         // year down never wraps
         if (field == FIELD_YEAR && target > cur) down_dist = span;
         // a day past the month length goes back to 1 on the way up
         if (field == FIELD_DAY && cur > span) up_dist = 0;
         send_request((down_dist < up_dist) ? MODE_DOWN : MODE_UP, field);
         cur = field_now(field);
      end
   endtask

   // bring the calendar close to a carry, then tick through it
   task automatic rollover_run();
      int target, eff, n;
      target = $urandom_range(0, 1) ? 99 : $urandom_range(0, 99);
      walk_field(FIELD_YEAR, target);
      target = $urandom_range(0, 1) ? 12 : $urandom_range(1, 12);
      walk_field(FIELD_MONTH, target);
      target = $urandom_range(0, 1) ? int'(days_in_month(model_cal.month))
                                    : $urandom_range(1, days_in_month(model_cal.month));
      walk_field(FIELD_DAY, target);
      target = $urandom_range(0, 1) ? 23 : $urandom_range(0, 23);
      walk_field(FIELD_HOUR, target);
      target = $urandom_range(0, 1) ? 59 : $urandom_range(0, 59);
      walk_field(FIELD_MINUTE, target);
      eff = (model_cfg.ticks_per_minute == 0) ? 1 : int'(model_cfg.ticks_per_minute);
      n   = 2 * eff + 1;
      if (n > 40) n = $urandom_range(1, 40);
      repeat (n) send_request(MODE_TICK, 3'($urandom_range(0, 7)));
   endtask

   task automatic test_random_traffic();
      int kind, n;
      logic [2:0] field;
      logic [1:0] dir;
      random_settings();
      while (requests_sent < TOTAL_REQUESTS) begin
         gaps_on   = ($urandom_range(0, 4) != 0);
         stalls_on = ($urandom_range(0, 4) != 0);
         kind = $urandom_range(0, 99);
         if (kind < 10) begin
            random_settings();
         end else if (kind < 35) begin
            // tick runs with a little noise mixed in
            repeat ($urandom_range(1, 40)) begin
               if ($urandom_range(0, 9) == 0)
                  send_request(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
               else
                  send_request(MODE_TICK, 3'($urandom_range(0, 7)));
            end
         end else if (kind < 55) begin
            // repeated steps of one field, reaching wraps and saturation
            field = 3'($urandom_range(0, 4));
            dir   = $urandom_range(0, 1) ? MODE_UP : MODE_DOWN;
            n     = $urandom_range(1, 30);
            repeat (n) send_request(dir, field);
         end else if (kind < 70) begin
            repeat ($urandom_range(1, 10))
               send_request(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
         end else begin
            rollover_run();
         end
      end
   endtask

   // main sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_unused_codes();
      test_minute_hour_steps();
      test_day_month_steps();
      test_year_steps();
      test_tick_carry();
      test_prescale();
      test_random_traffic();
      wait_for_results();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && expected_readings.size() == 0) begin
         $display("tb_rtc_calendar_alarm OK");
      end else begin
         $display("tb_rtc_calendar_alarm NOT OK");
      end
      $finish;
   end

endmodule
